FILE: hw/rtl/iger_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants of the isometric grid edge rasterizer.
// Used by the controller, the datapath and the top level; depends on nothing.

package iger_pkg;

  // field widths of the request and result items
  localparam int IDX_W     = 10;
  localparam int HEIGHT_W  = 11;
  localparam int PIX_W     = 16;
  localparam int COLOR_W   = 24;

  // configuration register widths
  localparam int ZOOM_W    = 8;
  localparam int SCALE_W   = 4;
  localparam int OFFS_W    = 12;

  // internal widths: lift fits 16 bits signed, screen coordinates 22 bits signed,
  // an edge spans fewer than 2^15 pixels
  localparam int LIFT_W    = 16;
  localparam int COORD_W   = 22;
  localparam int SPAN_W    = 15;

  // stream payload widths
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 56;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [CFG_IDX_W-1:0] REG_ZOOM         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_SCALE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_X_OFFSET     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_OFFSET     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR        = 3'd4;

  // register values after reset
  localparam logic [ZOOM_W-1:0]  ZOOM_RST         = 8'd20;
  localparam logic [SCALE_W-1:0] HEIGHT_SCALE_RST = 4'd1;
  localparam logic [OFFS_W-1:0]  X_OFFSET_RST     = 12'd600;
  localparam logic [OFFS_W-1:0]  Y_OFFSET_RST     = 12'd200;
  localparam logic [COLOR_W-1:0] COLOR_RST        = 24'hFFFFFF;

  typedef struct packed {
    logic [ZOOM_W-1:0]  zoom;
    logic [SCALE_W-1:0] height_scale;
    logic [OFFS_W-1:0]  x_offset;
    logic [OFFS_W-1:0]  y_offset;
    logic [COLOR_W-1:0] color;
  } iger_cfg_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load_in;
    logic calc_grid;
    logic calc_screen;
    logic calc_span;
    logic div_load;
    logic div_step;
    logic mul;
    logic hop_adj;
    logic emit_step;
  } iger_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic div_done;
    logic last_pixel;
    logic out_free;
  } iger_sts_t;

endpackage

FILE: hw/rtl/iger_div.sv
`timescale 1ns / 1ps
// Two-lane radix-4 restoring divider for both DDA steps.
// Depends on iger_pkg; used by iger_datapath.

module iger_div import iger_pkg::*; #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     load_i,
  input  logic                     step_i,
  input  logic [SPAN_W-1:0]        num_x_i,
  input  logic [SPAN_W-1:0]        num_y_i,
  input  logic [SPAN_W-1:0]        den_i,
  output logic [FRACTION_BITS:0]   quo_x_o,
  output logic [FRACTION_BITS:0]   quo_y_o,
  output logic                     done_o
);

  localparam int DIV_STEPS = (SPAN_W + FRACTION_BITS + 1) / 2;
  localparam int DW        = 2 * DIV_STEPS;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);
  localparam int LANES     = 2;

  logic [DW-1:0]     num_q [LANES];
  logic [DW-1:0]     num_d [LANES];
  logic [DW-1:0]     quo_q [LANES];
  logic [DW-1:0]     quo_d [LANES];
  logic [SPAN_W-1:0] rem_q [LANES];
  logic [SPAN_W-1:0] rem_d [LANES];
  logic [SPAN_W-1:0] den_q [LANES];
  logic [CNT_W-1:0]  cnt_q;

  // two quotient bits per lane in each cycle with step_i high, numerator bits shifted in msb first
  always_comb begin
    logic [SPAN_W-1:0] r;
    logic [SPAN_W:0]   t;
    logic [DW-1:0]     nm;
    logic [DW-1:0]     qq;
    for (int l = 0; l < LANES; l++) begin
      r  = rem_q[l];
      nm = num_q[l];
      qq = quo_q[l];
      for (int s = 0; s < 2; s++) begin
        t  = {r, nm[DW-1]};
        nm = {nm[DW-2:0], 1'b0};
        if (t >= {1'b0, den_q[l]}) begin
          t  = t - {1'b0, den_q[l]};
          qq = {qq[DW-2:0], 1'b1};
        end else begin
          qq = {qq[DW-2:0], 1'b0};
        end
        r = t[SPAN_W-1:0];
      end
      rem_d[l] = r;
      num_d[l] = nm;
      quo_d[l] = qq;
    end
  end

  // lane registers
  always_ff @(posedge clk_i) begin
    if (load_i) begin
      num_q[0] <= DW'(num_x_i) << FRACTION_BITS;
      num_q[1] <= DW'(num_y_i) << FRACTION_BITS;
      den_q[0] <= den_i;
      den_q[1] <= den_i;
      for (int l = 0; l < LANES; l++) begin
        rem_q[l] <= '0;
        quo_q[l] <= '0;
      end
    end else if (step_i) begin
      for (int l = 0; l < LANES; l++) begin
        rem_q[l] <= rem_d[l];
        num_q[l] <= num_d[l];
        quo_q[l] <= quo_d[l];
      end
    end
  end

  // iteration counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (load_i) begin
      cnt_q <= CNT_W'(DIV_STEPS);
    end else if (step_i) begin
      cnt_q <= cnt_q - 1'b1;
    end
  end

  assign done_o  = (cnt_q == '0);
  assign quo_x_o = quo_q[0][FRACTION_BITS:0];
  assign quo_y_o = quo_q[1][FRACTION_BITS:0];

  // no iteration past the end of a division
  a_no_step_when_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i |-> (cnt_q != '0))
    else $error("divider stepped after completion");

endmodule

FILE: hw/rtl/iger_datapath.sv
`timescale 1ns / 1ps
// Datapath: projection of both endpoints, span and steps, DDA walk, pixel register.
// Depends on iger_pkg and iger_div; driven by iger_ctrl through iger_cmd_t.

module iger_datapath import iger_pkg::*; #(
  parameter int MAX_SPAN      = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  iger_cfg_t                   cfg_i,
  input  iger_cmd_t                   cmd_i,
  output iger_sts_t                   sts_o,
  input  logic                        kind_i,
  input  logic [IDX_W-1:0]            line_pos_i,
  input  logic [IDX_W-1:0]            edge_index_i,
  input  logic signed [HEIGHT_W-1:0]  height_first_i,
  input  logic signed [HEIGHT_W-1:0]  height_second_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [PIX_W-1:0]            pixel_x_o,
  output logic [PIX_W-1:0]            pixel_y_o,
  output logic [COLOR_W-1:0]          pixel_color_o,
  output logic                        last_pixel_o,
  output logic                        clipped_o
);

  localparam int STEP_W = FRACTION_BITS + 2;
  localparam int PROD_W = SPAN_W + FRACTION_BITS + 2;
  localparam int AW     = COORD_W + FRACTION_BITS + 1;
  localparam int RW     = $clog2(MAX_SPAN);
  localparam int GP_W   = IDX_W + ZOOM_W;

  // sample spacing n / (MAX_SPAN - 1) by reciprocal multiplication, exact for any span
  localparam int KDEN    = MAX_SPAN - 1;
  localparam int RECIP_S = SPAN_W + $clog2(KDEN);
  localparam int RECIP_W = SPAN_W + 2;
  localparam int KP_W    = SPAN_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_M = RECIP_W'(((1 << RECIP_S) + KDEN - 1) / KDEN);

  // lift of one endpoint, zero for height zero
  function automatic logic signed [LIFT_W-1:0] lift_of(logic signed [HEIGHT_W-1:0] h,
                                                      logic [ZOOM_W-1:0] z,
                                                      logic [SCALE_W-1:0] s);
    logic signed [HEIGHT_W:0]   base;
    logic signed [LIFT_W-1:0]   prod;
    base = (HEIGHT_W+1)'(h) + (HEIGHT_W+1)'({1'b0, z});
    prod = LIFT_W'(base) * LIFT_W'(signed'({1'b0, s}));
    return (h == '0) ? '0 : prod;
  endfunction

  // divide by two, rounding toward zero
  function automatic logic signed [COORD_W-1:0] half_tz(logic signed [COORD_W-1:0] v);
    logic signed [COORD_W-1:0] sh;
    sh = v >>> 1;
    if (v[COORD_W-1] && v[0]) sh = sh + COORD_W'(1'b1);
    return sh;
  endfunction

  // integer part of a walk position, rounding toward zero, wrapped to 16 bits
  function automatic logic [PIX_W-1:0] walk_pixel(logic signed [AW-1:0] v);
    logic signed [AW-1:0] sh;
    logic [PIX_W-1:0]     lo;
    sh = v >>> FRACTION_BITS;
    lo = sh[PIX_W-1:0];
    if (v[AW-1] && (v[FRACTION_BITS-1:0] != '0)) lo = lo + 1'b1;
    return lo;
  endfunction

  // request registers
  logic                        kind_q;
  logic [IDX_W-1:0]            line_q;
  logic [IDX_W-1:0]            edge_q;
  logic signed [HEIGHT_W-1:0]  h1_q;
  logic signed [HEIGHT_W-1:0]  h2_q;

  // grid stage
  logic [GP_W-1:0]             edge_prod;
  logic [GP_W-1:0]             line_prod;
  logic signed [COORD_W-1:0]   far_q, near_q, lineg_q;
  logic signed [LIFT_W-1:0]    lift1_q, lift2_q;

  // screen stage
  logic signed [COORD_W-1:0]   gx1, gy1, gx2, gy2;
  logic signed [COORD_W-1:0]   xoff_ext, yoff_ext;
  logic signed [COORD_W-1:0]   sum1, sum2;
  logic signed [COORD_W-1:0]   sx1_q, sy1_q, sx2_q, sy2_q;

  // span stage
  logic signed [COORD_W-1:0]   dx, dy, adx, ady;
  logic [SPAN_W-1:0]           adx_s, ady_s;
  logic [SPAN_W-1:0]           adx_q, ady_q, n_q;
  logic                        sgn_x_q, sgn_y_q;
  logic                        clip_q;
  logic [SPAN_W-1:0]           last_idx_q;

  // divider results, sample spacing and step products
  logic [FRACTION_BITS:0]      quo_x, quo_y;
  logic [KP_W-1:0]             kprod;
  logic [SPAN_W-1:0]           quo_k_q;
  logic [SPAN_W-1:0]           kback;
  logic [SPAN_W-1:0]           rem_k;
  logic                        div_done;
  logic signed [STEP_W-1:0]    step_x, step_y;
  logic signed [STEP_W-1:0]    step_x_q, step_y_q;
  logic signed [PROD_W-1:0]    hop_x_q, hop_y_q, hop_hi_x_q, hop_hi_y_q;
  logic [RW-1:0]               kr0_q;

  // walk state
  logic signed [AW-1:0]        acc_x_q, acc_y_q;
  logic signed [AW-1:0]        inc_x, inc_y;
  logic [SPAN_W-1:0]           idx_q;
  logic [RW-1:0]               krem_q, krem_d;
  logic [RW:0]                 ksum, klimit, kdiff;
  logic                        carry;
  logic                        is_last;
  logic [PIX_W-1:0]            px, py;

  // output register
  logic                        out_valid_q;
  logic [PIX_W-1:0]            out_x_q, out_y_q;
  logic [COLOR_W-1:0]          out_color_q;
  logic                        out_last_q, out_clip_q;

  // capture the request
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      kind_q <= kind_i;
      line_q <= line_pos_i;
      edge_q <= edge_index_i;
      h1_q   <= height_first_i;
      h2_q   <= height_second_i;
    end
  end

  // grid positions and lifts
  assign edge_prod = GP_W'(edge_q) * GP_W'(cfg_i.zoom);
  assign line_prod = GP_W'(line_q) * GP_W'(cfg_i.zoom);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_grid) begin
      far_q   <= signed'(COORD_W'(edge_prod));
      near_q  <= signed'(COORD_W'(edge_prod)) - signed'(COORD_W'(cfg_i.zoom));
      lineg_q <= signed'(COORD_W'(line_prod));
      lift1_q <= lift_of(h1_q, cfg_i.zoom, cfg_i.height_scale);
      lift2_q <= lift_of(h2_q, cfg_i.zoom, cfg_i.height_scale);
    end
  end

  // isometric projection of both endpoints
  always_comb begin
    gx1      = kind_q ? lineg_q : near_q;
    gy1      = kind_q ? near_q  : lineg_q;
    gx2      = kind_q ? lineg_q : far_q;
    gy2      = kind_q ? far_q   : lineg_q;
    xoff_ext = signed'(COORD_W'(cfg_i.x_offset));
    yoff_ext = signed'(COORD_W'(cfg_i.y_offset));
    sum1     = gx1 + gy1 - COORD_W'(lift1_q);
    sum2     = gx2 + gy2 - COORD_W'(lift2_q);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_screen) begin
      sx1_q <= gx1 - gy1 + xoff_ext;
      sx2_q <= gx2 - gy2 + xoff_ext;
      sy1_q <= half_tz(sum1) + yoff_ext;
      sy2_q <= half_tz(sum2) + yoff_ext;
    end
  end

  // deltas, magnitudes and pixel span
  always_comb begin
    dx    = sx2_q - sx1_q;
    dy    = sy2_q - sy1_q;
    adx   = dx[COORD_W-1] ? -dx : dx;
    ady   = dy[COORD_W-1] ? -dy : dy;
    adx_s = adx[SPAN_W-1:0];
    ady_s = ady[SPAN_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc_span) begin
      adx_q   <= adx_s;
      ady_q   <= ady_s;
      n_q     <= (adx_s > ady_s) ? adx_s : ady_s;
      sgn_x_q <= dx[COORD_W-1];
      sgn_y_q <= dy[COORD_W-1];
    end
  end

  // sample spacing quotient and its remainder
  assign kprod = KP_W'(n_q) * KP_W'(RECIP_M);
  assign kback = quo_k_q * SPAN_W'(KDEN);
  assign rem_k = n_q - kback;

  // sampling decision
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_load) begin
      clip_q     <= (n_q >= SPAN_W'(MAX_SPAN));
      last_idx_q <= (n_q >= SPAN_W'(MAX_SPAN)) ? SPAN_W'(MAX_SPAN - 1) : n_q;
      quo_k_q    <= SPAN_W'(kprod >> RECIP_S);
    end
  end

  iger_div #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (cmd_i.div_load),
    .step_i  (cmd_i.div_step),
    .num_x_i (adx_q),
    .num_y_i (ady_q),
    .den_i   (n_q),
    .quo_x_o (quo_x),
    .quo_y_o (quo_y),
    .done_o  (div_done)
  );

  // signed steps and the per-sample hop
  assign step_x = sgn_x_q ? -signed'({1'b0, quo_x}) : signed'({1'b0, quo_x});
  assign step_y = sgn_y_q ? -signed'({1'b0, quo_y}) : signed'({1'b0, quo_y});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      step_x_q <= step_x;
      step_y_q <= step_y;
      hop_x_q  <= PROD_W'(signed'({1'b0, quo_k_q})) * PROD_W'(step_x);
      hop_y_q  <= PROD_W'(signed'({1'b0, quo_k_q})) * PROD_W'(step_y);
      kr0_q    <= rem_k[RW-1:0];
    end
  end

  // hop plus one step, taken when the sample remainder wraps
  always_ff @(posedge clk_i) begin
    if (cmd_i.hop_adj) begin
      hop_hi_x_q <= hop_x_q + PROD_W'(step_x_q);
      hop_hi_y_q <= hop_y_q + PROD_W'(step_y_q);
    end
  end

  // sample index remainder against MAX_SPAN - 1
  always_comb begin
    ksum   = (RW+1)'(krem_q) + (RW+1)'(kr0_q);
    klimit = (RW+1)'(MAX_SPAN - 1);
    kdiff  = ksum - klimit;
    carry  = (ksum >= klimit);
    krem_d = carry ? kdiff[RW-1:0] : ksum[RW-1:0];
  end

  always_comb begin
    if (!clip_q) begin
      inc_x = AW'(step_x_q);
      inc_y = AW'(step_y_q);
    end else if (carry) begin
      inc_x = AW'(hop_hi_x_q);
      inc_y = AW'(hop_hi_y_q);
    end else begin
      inc_x = AW'(hop_x_q);
      inc_y = AW'(hop_y_q);
    end
  end

  // current pixel; the final one lands exactly on the far endpoint
  assign is_last = (idx_q == last_idx_q);
  assign px      = is_last ? sx2_q[PIX_W-1:0] : walk_pixel(acc_x_q);
  assign py      = is_last ? sy2_q[PIX_W-1:0] : walk_pixel(acc_y_q);

  // walk registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.hop_adj) begin
      acc_x_q <= AW'(sx1_q) << FRACTION_BITS;
      acc_y_q <= AW'(sy1_q) << FRACTION_BITS;
      idx_q   <= '0;
      krem_q  <= '0;
    end else if (cmd_i.emit_step) begin
      acc_x_q <= acc_x_q + inc_x;
      acc_y_q <= acc_y_q + inc_y;
      idx_q   <= idx_q + 1'b1;
      krem_q  <= krem_d;
    end
  end

  // output register, refilled while its content is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_step) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_step) begin
      out_x_q     <= px;
      out_y_q     <= py;
      out_color_q <= cfg_i.color;
      out_last_q  <= is_last;
      out_clip_q  <= clip_q;
    end
  end

  assign sts_o.div_done   = div_done;
  assign sts_o.last_pixel = is_last;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = out_x_q;
  assign pixel_y_o     = out_y_q;
  assign pixel_color_o = out_color_q;
  assign last_pixel_o  = out_last_q;
  assign clipped_o     = out_clip_q;

  // a stalled pixel stays valid and unchanged
  a_hold_while_stalled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=>
      (out_valid_q &&
       $stable({out_x_q, out_y_q, out_color_q, out_last_q, out_clip_q})))
    else $error("stalled pixel changed or was dropped");

endmodule

FILE: hw/rtl/iger_ctrl.sv
`timescale 1ns / 1ps
// Controller state machine: sequences projection, division, hop setup and the walk.
// Depends on iger_pkg; drives iger_datapath through iger_cmd_t.

module iger_ctrl import iger_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  iger_sts_t sts_i,
  output iger_cmd_t cmd_o
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_GRID   = 4'd1;
  localparam logic [3:0] ST_SCREEN = 4'd2;
  localparam logic [3:0] ST_SPAN   = 4'd3;
  localparam logic [3:0] ST_DLOAD  = 4'd4;
  localparam logic [3:0] ST_DIV    = 4'd5;
  localparam logic [3:0] ST_MUL    = 4'd6;
  localparam logic [3:0] ST_ADJ    = 4'd7;
  localparam logic [3:0] ST_EMIT   = 4'd8;

  logic [3:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = ST_GRID;
        end
      end
      ST_GRID: begin
        cmd_o.calc_grid = 1'b1;
        state_d         = ST_SCREEN;
      end
      ST_SCREEN: begin
        cmd_o.calc_screen = 1'b1;
        state_d           = ST_SPAN;
      end
      ST_SPAN: begin
        cmd_o.calc_span = 1'b1;
        state_d         = ST_DLOAD;
      end
      ST_DLOAD: begin
        cmd_o.div_load = 1'b1;
        state_d        = ST_DIV;
      end
      ST_DIV: begin
        if (sts_i.div_done) begin
          state_d = ST_MUL;
        end else begin
          cmd_o.div_step = 1'b1;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADJ;
      end
      ST_ADJ: begin
        cmd_o.hop_adj = 1'b1;
        state_d       = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.emit_step = 1'b1;
          if (sts_i.last_pixel) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a pixel is only pushed into a free output register
  a_emit_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit_step |-> sts_i.out_free)
    else $error("pixel pushed into an occupied output register");

  // an accepted request always starts the grid stage next
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_GRID))
    else $error("accepted request did not start processing");

endmodule

FILE: hw/rtl/isometric_grid_edge_rasterizer.sv
`timescale 1ns / 1ps
// Top level: configuration registers, stream packing, controller and datapath.
// Depends on iger_pkg, iger_ctrl and iger_datapath.

// One request is one wireframe edge; the block answers with its pixels, one per
// stream beat, the final one marked with tlast and every beat of a sampled edge
// marked in tuser. A request is taken only when the previous edge has placed its
// final pixel in the output register. Per edge the block captures the request,
// projects both endpoints, forms the span and loads the divider, runs the two-lane
// radix-4 divider that forms both DDA steps, forms the hop products, then emits
// one pixel per cycle while the output is free: min(span + 1, MAX_SPAN) pixels.
// Configuration writes belong in idle time only.

module isometric_grid_edge_rasterizer import iger_pkg::*; #(
  parameter int MAX_SPAN      = 64,
  parameter int FRACTION_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  // configuration write port
  input  logic                   cfg_we_i,
  input  logic [CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i,
  // edge requests
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // line_pos, edge_index, height_first,
                                                // height_second, zero fill
  input  logic                   s_axis_tuser,  // kind
  // pixels
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // pixel_x, pixel_y, pixel_color
  output logic                   m_axis_tlast,  // last_pixel
  output logic                   m_axis_tuser   // clipped
);

  iger_cfg_t cfg_q;
  iger_cmd_t cmd;
  iger_sts_t sts;

  logic [PIX_W-1:0]   pixel_x;
  logic [PIX_W-1:0]   pixel_y;
  logic [COLOR_W-1:0] pixel_color;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.zoom         <= ZOOM_RST;
      cfg_q.height_scale <= HEIGHT_SCALE_RST;
      cfg_q.x_offset     <= X_OFFSET_RST;
      cfg_q.y_offset     <= Y_OFFSET_RST;
      cfg_q.color        <= COLOR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_ZOOM:         cfg_q.zoom         <= cfg_data_i[ZOOM_W-1:0];
        REG_HEIGHT_SCALE: cfg_q.height_scale <= cfg_data_i[SCALE_W-1:0];
        REG_X_OFFSET:     cfg_q.x_offset     <= cfg_data_i[OFFS_W-1:0];
        REG_Y_OFFSET:     cfg_q.y_offset     <= cfg_data_i[OFFS_W-1:0];
        REG_COLOR:        cfg_q.color        <= cfg_data_i[COLOR_W-1:0];
        default: begin
        end
      endcase
    end
  end

  iger_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  iger_datapath #(
    .MAX_SPAN      (MAX_SPAN),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .kind_i          (s_axis_tuser),
    .line_pos_i      (s_axis_tdata[9:0]),
    .edge_index_i    (s_axis_tdata[19:10]),
    .height_first_i  (signed'(s_axis_tdata[30:20])),
    .height_second_i (signed'(s_axis_tdata[41:31])),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .pixel_x_o       (pixel_x),
    .pixel_y_o       (pixel_y),
    .pixel_color_o   (pixel_color),
    .last_pixel_o    (m_axis_tlast),
    .clipped_o       (m_axis_tuser)
  );

  // pixel payload, first field in the low bits
  assign m_axis_tdata = {pixel_color, pixel_y, pixel_x};

endmodule

FILE: bench/isometric_grid_edge_rasterizer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the isometric grid edge rasterizer: streams wireframe
// edges under several register settings and checks every pixel against a local model.
// Depends on iger_pkg and the isometric_grid_edge_rasterizer RTL.

module isometric_grid_edge_rasterizer_tb;
  import iger_pkg::*;

  localparam int MAX_SPAN      = 64;
  localparam int FRACTION_BITS = 16;
  localparam int REPORT_LIMIT  = 10;
  localparam int SETTLE_CYCLES = 40;
  localparam longint FIX_ONE   = longint'(1) << FRACTION_BITS;

  // edge orientation carried in tuser
  localparam logic KIND_ROW = 1'b0;
  localparam logic KIND_COL = 1'b1;

  typedef struct {
    logic                kind;
    logic [IDX_W-1:0]    line_pos;
    logic [IDX_W-1:0]    edge_index;
    logic [HEIGHT_W-1:0] height_first;
    logic [HEIGHT_W-1:0] height_second;
  } edge_req_t;

  typedef struct {
    logic [PIX_W-1:0]   x;
    logic [PIX_W-1:0]   y;
    logic [COLOR_W-1:0] color;
    logic               last;
    logic               clipped;
  } pixel_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i = '0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   m_axis_tlast;
  logic                   m_axis_tuser;

  // register copy, pending requests and expected pixels
  iger_cfg_t reg_shadow = '{zoom: ZOOM_RST, height_scale: HEIGHT_SCALE_RST,
                            x_offset: X_OFFSET_RST, y_offset: Y_OFFSET_RST,
                            color: COLOR_RST};
  edge_req_t edge_queue[$];
  edge_req_t req_on_bus;
  pixel_t    pixel_queue[$];
  bit        req_taken = 1'b0;
  int        sender_idle_pct = 0;
  int        receiver_idle_pct = 0;

  int failures = 0;
  int edges_done = 0;
  int pixels_checked = 0;
  int sampled_edges = 0;
  int single_pixel_edges = 0;

  isometric_grid_edge_rasterizer #(
    .MAX_SPAN      (MAX_SPAN),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // lift of one endpoint; a zero height stays on the ground plane
  function automatic longint endpoint_lift(input logic [HEIGHT_W-1:0] h);
    if (h == '0) return 0;
    return (longint'(reg_shadow.zoom) + longint'($signed(h))) *
           longint'(reg_shadow.height_scale);
  endfunction

  // fixed-point position after k steps, truncated toward zero
  function automatic longint dda_point(input longint start, input longint step,
                                       input longint k);
    return (start * FIX_ONE + k * step) / FIX_ONE;
  endfunction

  // project one edge and queue every pixel it should produce
  function automatic void project_edge(input edge_req_t r);
    longint zm, lift_near, lift_far, near_idx, far_idx, fixed_idx;
    longint gx1, gy1, gx2, gy2, sx1, sy1, sx2, sy2;
    longint dx, dy, adx, ady, n, step_x, step_y, count, k, px, py;
    logic   clip;
    pixel_t pix;
    zm        = longint'(reg_shadow.zoom);
    lift_near = endpoint_lift(r.height_first);
    lift_far  = endpoint_lift(r.height_second);
    near_idx  = (longint'(r.edge_index) - 1) * zm;
    far_idx   = longint'(r.edge_index) * zm;
    fixed_idx = longint'(r.line_pos) * zm;
    if (r.kind == KIND_ROW) begin
      gx1 = near_idx;  gx2 = far_idx;
      gy1 = fixed_idx; gy2 = fixed_idx;
    end else begin
      gx1 = fixed_idx; gx2 = fixed_idx;
      gy1 = near_idx;  gy2 = far_idx;
    end
    sx1 = gx1 - gy1 + longint'(reg_shadow.x_offset);
    sx2 = gx2 - gy2 + longint'(reg_shadow.x_offset);
    sy1 = (gx1 + gy1 - lift_near) / 2 + longint'(reg_shadow.y_offset);
    sy2 = (gx2 + gy2 - lift_far) / 2 + longint'(reg_shadow.y_offset);
    dx  = sx2 - sx1;
    dy  = sy2 - sy1;
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    n   = (adx > ady) ? adx : ady;
    step_x = 0;
    step_y = 0;
    if (n > 0) begin
      step_x = (dx * FIX_ONE) / n;
      step_y = (dy * FIX_ONE) / n;
    end
    clip  = (n + 1) > MAX_SPAN;
    count = clip ? MAX_SPAN : n + 1;
    // long edges are sampled evenly; the final pixel is always the far endpoint
    for (longint i = 0; i < count; i++) begin
      k = clip ? (i * n) / (MAX_SPAN - 1) : i;
      if (i == count - 1) begin
        px = sx2;
        py = sy2;
      end else begin
        px = dda_point(sx1, step_x, k);
        py = dda_point(sy1, step_y, k);
      end
      pix.x       = px[PIX_W-1:0];
      pix.y       = py[PIX_W-1:0];
      pix.color   = reg_shadow.color;
      pix.last    = (i == count - 1);
      pix.clipped = clip;
      pixel_queue.push_back(pix);
    end
    edges_done++;
    if (clip) sampled_edges++;
    if (n == 0) single_pixel_edges++;
  endfunction

  function automatic void note_failure(input string msg);
    failures++;
    if (failures <= REPORT_LIMIT) $display("%s", msg);
  endfunction

  // request driver: holds a request until taken, idles at random
  always @(negedge clk_i) begin
    if (rst_ni && !(s_axis_tvalid && !req_taken)) begin
      req_taken = 1'b0;
      if (edge_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        req_on_bus = edge_queue.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= req_on_bus.kind;
        s_axis_tdata  <= IN_TDATA_W'({req_on_bus.height_second, req_on_bus.height_first,
                                      req_on_bus.edge_index, req_on_bus.line_pos});
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // pixel sink back-pressure
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && ($urandom_range(99) >= receiver_idle_pct);
  end

  // predict on each accepted request, check each accepted pixel
  always @(posedge clk_i) begin : pixel_check
    pixel_t want;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        project_edge(req_on_bus);
        req_taken = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_queue.size() == 0) begin
          note_failure($sformatf("unexpected pixel x %0d y %0d color %06h last %0b clip %0b",
                                 $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
                                 m_axis_tdata[55:32], m_axis_tlast, m_axis_tuser));
        end else begin
          want = pixel_queue.pop_front();
          pixels_checked++;
          if (m_axis_tdata[15:0] !== want.x || m_axis_tdata[31:16] !== want.y ||
              m_axis_tdata[55:32] !== want.color || m_axis_tlast !== want.last ||
              m_axis_tuser !== want.clipped) begin
            note_failure($sformatf(
              "pixel mismatch: got x %0d y %0d color %06h last %0b clip %0b, %s",
              $signed(m_axis_tdata[15:0]), $signed(m_axis_tdata[31:16]),
              m_axis_tdata[55:32], m_axis_tlast, m_axis_tuser,
              $sformatf("expected x %0d y %0d color %06h last %0b clip %0b",
                        $signed(want.x), $signed(want.y), want.color, want.last,
                        want.clipped)));
          end
        end
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    case (idx)
      REG_ZOOM:         reg_shadow.zoom         = value[ZOOM_W-1:0];
      REG_HEIGHT_SCALE: reg_shadow.height_scale = value[SCALE_W-1:0];
      REG_X_OFFSET:     reg_shadow.x_offset     = value[OFFS_W-1:0];
      REG_Y_OFFSET:     reg_shadow.y_offset     = value[OFFS_W-1:0];
      REG_COLOR:        reg_shadow.color        = value[COLOR_W-1:0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_settings(input logic [CFG_DATA_W-1:0] zoom_v,
                               input logic [CFG_DATA_W-1:0] scale_v,
                               input logic [CFG_DATA_W-1:0] xoff_v,
                               input logic [CFG_DATA_W-1:0] yoff_v,
                               input logic [CFG_DATA_W-1:0] color_v);
    write_reg(REG_ZOOM, zoom_v);
    write_reg(REG_HEIGHT_SCALE, scale_v);
    write_reg(REG_X_OFFSET, xoff_v);
    write_reg(REG_Y_OFFSET, yoff_v);
    write_reg(REG_COLOR, color_v);
  endtask

  function automatic void push_edge(input logic kind, input int line_v, input int idx_v,
                                    input int h1, input int h2);
    edge_req_t r;
    r.kind          = kind;
    r.line_pos      = IDX_W'(line_v);
    r.edge_index    = IDX_W'(idx_v);
    r.height_first  = HEIGHT_W'(h1);
    r.height_second = HEIGHT_W'(h2);
    edge_queue.push_back(r);
  endfunction

  // heights lean toward small relief so many edges stay under the span limit
  function automatic int random_height();
    case ($urandom_range(9))
      0, 1, 2, 3: return int'($urandom_range(60)) - 30;
      4, 5:       return int'($urandom_range(2047)) - 1024;
      6:          return 0;
      7:          return $urandom_range(1) ? 1023 : -1024;
      default:    return int'($urandom_range(510)) - 255;
    endcase
  endfunction

  function automatic void queue_random_edges(input int count);
    int line_v, idx_v, h1, h2;
    for (int i = 0; i < count; i++) begin
      line_v = $urandom_range(1) ? $urandom_range(15) : $urandom_range(1023);
      idx_v  = $urandom_range(1) ? $urandom_range(1, 15) : $urandom_range(1, 1023);
      h1     = random_height();
      h2     = ($urandom_range(4) == 0) ? h1 : random_height();
      push_edge($urandom_range(1) ? KIND_COL : KIND_ROW, line_v, idx_v, h1, h2);
    end
  endfunction

  // hold off new requests until every expected pixel is back, then let it settle
  task automatic drain();
    while (edge_queue.size() != 0 || s_axis_tvalid || pixel_queue.size() != 0)
      @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);

    // reset settings: directed corners, then random edges
    sender_idle_pct   = 21;
    receiver_idle_pct = 59;
    push_edge(KIND_ROW, 0, 1, 0, 0);
    push_edge(KIND_COL, 0, 1, 0, 0);
    push_edge(KIND_ROW, 1023, 1023, 1023, -1024);
    push_edge(KIND_COL, 1023, 1023, -1024, 1023);
    push_edge(KIND_ROW, 5, 0, 3, 3);
    push_edge(KIND_COL, 7, 0, 0, 10);
    push_edge(KIND_ROW, 10, 10, 1, -1);
    push_edge(KIND_COL, 3, 4, 30, 0);
    push_edge(KIND_ROW, 0, 1, -20, 0);
    push_edge(KIND_COL, 2, 2, 22, 22);
    push_edge(KIND_ROW, 512, 512, 1023, 1023);
    push_edge(KIND_COL, 1, 1022, -1024, -1024);
    // edge of exactly MAX_SPAN pixels, then one of one pixel more
    push_edge(KIND_ROW, 0, 1, 0, 126);
    push_edge(KIND_ROW, 0, 1, 0, 128);
    queue_random_edges(40);
    drain();

    // top of every register range; coordinates wrap
    load_settings(255, 15, 4095, 4095, 24'hFFFFFF);
    queue_random_edges(40);
    drain();

    // bottom of every register range but zoom, which is one
    sender_idle_pct   = 59;
    receiver_idle_pct = 21;
    load_settings(1, 0, 0, 0, 0);
    queue_random_edges(40);
    drain();

    // zoom zero collapses the grid; equal heights give one-pixel edges
    load_settings(0, $urandom_range(15), $urandom_range(4095), $urandom_range(4095),
                  $urandom_range(24'hFFFFFF));
    push_edge(KIND_ROW, 0, 1, 0, 0);
    push_edge(KIND_COL, 100, 5, 5, 5);
    queue_random_edges(30);
    drain();

    // random settings with no idling on either side
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    load_settings($urandom_range(1, 255), $urandom_range(15), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(24'hFFFFFF));
    queue_random_edges(50);
    drain();
    load_settings($urandom_range(1, 8), $urandom_range(15), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(24'hFFFFFF));
    queue_random_edges(50);
    drain();
    load_settings($urandom_range(1, 255), $urandom_range(15), $urandom_range(4095),
                  $urandom_range(4095), $urandom_range(24'hFFFFFF));
    queue_random_edges(50);
    drain();

    $display("run covered %0d edges under seven register settings, %0d pixels compared",
             edges_done, pixels_checked);
    $display("%0d edges were sampled at the span limit, %0d collapsed to one pixel",
             sampled_edges, single_pixel_edges);
    if (failures == 0 && pixel_queue.size() == 0) begin
      $display("isometric_grid_edge_rasterizer regression: pass");
    end else begin
      $display("isometric_grid_edge_rasterizer regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("timeout with %0d pixels outstanding", pixel_queue.size());
    $display("isometric_grid_edge_rasterizer regression: fail");
    $finish;
  end

endmodule
